// ===== rtl/m4m_pkg.sv =====
// Shared types and constants for the fixed-point square matrix multiplier.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package m4m_pkg;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 32;

  // Operation code carried by each input word. The fourth code is unused.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_LEFT  = 2'd0,
    KIND_LOAD_RIGHT = 2'd1,
    KIND_COMPUTE    = 2'd2
  } kind_t;

  // Product sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOLD,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

endpackage

// ===== rtl/matrix4x4_multiply.sv =====
// Fixed-point square matrix multiplier built around two operand memories.
// Depends on m4m_pkg for widths, operation codes and the sequencer states.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Fields
// item      in         item_valid / item_stall   kind, element_index, element_value
// result    out        result_valid / result_stall
//                                                out_index, out_value, saturated, last
//
// A load word writes one entry of the left or right store.
// A compute word emits DIM*DIM results; each sums DIM operand reads through the
// single multiplier, then passes the multiply and accumulate stages and the
// hand-off to the output register, one result at a time.
// Reset is synchronous and clears the entry valid bits, so both stores read as zero.
// item_stall is high from a compute word until its final result sits in the
// output register; result_stall only delays the start of the next element.

module matrix4x4_multiply #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [m4m_pkg::KIND_W-1:0]  kind,
  input  logic [m4m_pkg::IDX_W-1:0]   element_index,
  input  logic [m4m_pkg::VAL_W-1:0]   element_value,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [m4m_pkg::IDX_W-1:0]   out_index,
  output logic [m4m_pkg::VAL_W-1:0]   out_value,
  output logic                        saturated,
  output logic                        last
);

  import m4m_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int KW    = $clog2(DIM);
  // Sum of DIM exact 64-bit products plus a sign bit never overflows this.
  localparam int ACC_W = 65 + $clog2(DIM);

  // Operand memories. Each entry has a valid bit that reset clears, and an
  // entry that was never loaded reads as zero.
  logic [VAL_W-1:0] left_mem  [CELLS];
  logic [VAL_W-1:0] right_mem [CELLS];
  logic [CELLS-1:0] left_ok;
  logic [CELLS-1:0] right_ok;

  state_t state;
  state_t state_next;

  // Sequencer outputs.
  logic start;
  logic issue;

  // Element and inner-product counters.
  logic [AW-1:0] elem;
  logic [AW-1:0] row_base;
  logic [AW-1:0] k_base;
  logic [AW-1:0] col;
  logic [KW-1:0] k;
  logic          k_last;
  logic [AW-1:0] l_addr;
  logic [AW-1:0] r_addr;

  // Stage 1: registered memory read data.
  logic             s1_valid;
  logic             s1_first;
  logic             s1_last;
  logic [AW-1:0]    s1_elem;
  logic [VAL_W-1:0] l_rd;
  logic [VAL_W-1:0] r_rd;
  logic             l_rd_ok;
  logic             r_rd_ok;
  logic signed [VAL_W-1:0] l_op;
  logic signed [VAL_W-1:0] r_op;

  // Stage 2: registered product.
  logic                      s2_valid;
  logic                      s2_first;
  logic                      s2_last;
  logic [AW-1:0]             s2_elem;
  logic signed [2*VAL_W-1:0] prod;

  // Stage 3: accumulator.
  logic                    acc_done;
  logic [AW-1:0]           acc_elem;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_add;

  // Output formatting.
  logic signed [ACC_W-1:0] shifted;
  logic                    fits;
  logic                    elem_final;
  logic                    out_free;

  logic          in_take;
  logic          load_ok;
  logic [AW-1:0] waddr;

  assign in_take = item_valid && !item_stall;
  assign load_ok = ({{(32 - IDX_W){1'b0}}, element_index} < 32'(CELLS));
  assign waddr   = AW'(element_index);

  // The output register is free, or its word leaves at this edge.
  assign out_free = !result_valid || !result_stall;

  // ---------------------------------------------------------------------
  // Sequencer: HOLD waits for the output register, ISSUE reads one operand
  // pair per cycle, DRAIN waits for the finished element to reach output.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && kind == KIND_COMPUTE) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_done) begin
          state_next = elem_final ? ST_IDLE : ST_HOLD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    start      = 1'b0;
    issue      = 1'b0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        start      = in_take && kind == KIND_COMPUTE;
      end
      ST_HOLD:  issue = 1'b0;
      ST_ISSUE: issue = 1'b1;
      ST_DRAIN: issue = 1'b0;
      default:  item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Element r*DIM+c reads left[r*DIM+k] and right[k*DIM+c] for each k.
  assign k_last = (k == KW'(DIM - 1));
  assign l_addr = row_base + AW'(k);
  assign r_addr = k_base + col;

  always_ff @(posedge clk) begin
    if (start) begin
      elem     <= '0;
      row_base <= '0;
      k_base   <= '0;
      col      <= '0;
      k        <= '0;
    end else if (issue) begin
      if (k_last) begin
        k      <= '0;
        k_base <= '0;
        elem   <= elem + AW'(1);
        if (col == AW'(DIM - 1)) begin
          col      <= '0;
          row_base <= row_base + AW'(DIM);
        end else begin
          col <= col + AW'(1);
        end
      end else begin
        k      <= k + KW'(1);
        k_base <= k_base + AW'(DIM);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Operand memories. Loads only arrive while the sequencer is idle, so a
  // write never meets a read of the same product.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take && load_ok && kind == KIND_LOAD_LEFT) begin
      left_mem[waddr] <= element_value;
    end
    if (in_take && load_ok && kind == KIND_LOAD_RIGHT) begin
      right_mem[waddr] <= element_value;
    end
    l_rd <= left_mem[l_addr];
    r_rd <= right_mem[r_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_ok  <= '0;
      right_ok <= '0;
    end else begin
      if (in_take && load_ok && kind == KIND_LOAD_LEFT) begin
        left_ok[waddr] <= 1'b1;
      end
      if (in_take && load_ok && kind == KIND_LOAD_RIGHT) begin
        right_ok[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    l_rd_ok  <= left_ok[l_addr];
    r_rd_ok  <= right_ok[r_addr];
    s1_first <= (k == '0);
    s1_last  <= k_last;
    s1_elem  <= elem;
  end

  // ---------------------------------------------------------------------
  // Multiply, accumulate, then shift and saturate into the output register.
  // ---------------------------------------------------------------------
  assign l_op = l_rd_ok ? $signed(l_rd) : '0;
  assign r_op = r_rd_ok ? $signed(r_rd) : '0;

  always_ff @(posedge clk) begin
    prod     <= l_op * r_op;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_elem  <= s1_elem;
  end

  assign acc_add = s2_first ? ACC_W'(prod) : acc + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc      <= acc_add;
      acc_elem <= s2_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      acc_done <= s2_valid && s2_last;
    end
  end

  // The sum fits when every bit from bit 31 upward matches the sign.
  assign shifted    = acc >>> FRAC_BITS;
  assign fits       = (&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]);
  assign elem_final = (acc_elem == AW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (acc_done) begin
      out_index <= IDX_W'(acc_elem);
      saturated <= !fits;
      last      <= elem_final;
      if (fits) begin
        out_value <= shifted[VAL_W-1:0];
      end else if (shifted[ACC_W-1]) begin
        out_value <= {1'b1, {(VAL_W - 1){1'b0}}};
      end else begin
        out_value <= {1'b0, {(VAL_W - 1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (acc_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/m4m_check.sv =====
// Port-level checks for the matrix multiplier, bound to its top level.
// Depends on m4m_pkg for the operation codes and field widths.
`timescale 1ns / 1ps

module m4m_check #(
  parameter int DIM = 4
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input logic [m4m_pkg::KIND_W-1:0]  kind,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [m4m_pkg::IDX_W-1:0]   out_index,
  input logic [m4m_pkg::VAL_W-1:0]   out_value,
  input logic                        saturated,
  input logic                        last
);

  import m4m_pkg::*;

  // A stalled result word keeps its contents.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_value) &&
      $stable(out_index) && $stable(saturated) && $stable(last))
    else $error("stalled result word changed");

  // Reset leaves no result word pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word visible after reset");

  // A compute word closes the input until its product is out.
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && kind == KIND_COMPUTE |=> item_stall)
    else $error("input open right after a compute word");

  // The final word of a product carries the last position.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> out_index == IDX_W'(DIM * DIM - 1))
    else $error("last marker on the wrong position");

  // While product words remain, the input stays closed.
  a_busy_midway: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !last |=> item_stall)
    else $error("input open in the middle of a product");

endmodule

bind matrix4x4_multiply m4m_check #(.DIM(DIM)) u_m4m_check (.*);

// ===== sim/tb.sv =====
// Self-checking bench for the fixed-point 4x4 matrix multiplier: loads, products, clamping.
// Depends on m4m_pkg for field widths and operation codes, and on the matrix4x4_multiply RTL.
`timescale 1ns / 1ps

module tb;
  import m4m_pkg::*;

  // The bench is written for the default 4x4 build with Q16.16 arithmetic.
  localparam int N         = 4;
  localparam int CELLS     = N * N;
  localparam int FRAC      = 16;

  // The fourth operation code has no name in the package; the block must ignore it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 76;
  localparam int CALM_AFTER   = 60;      // no idling on either side past this many words
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 40;      // quiet at the end, so a stray result word is still seen
  localparam int PRINT_CAP    = 40;

  // Bounds of a shifted dot-product sum that still fits in 32 bits.
  localparam logic signed [49:0] SUM_MAX = 50'sd2147483647;
  localparam logic signed [49:0] SUM_MIN = -50'sd2147483648;

  // One input word. When typed is set, the product it starts is checked against
  // first_value/first_sat in element 0 and zero everywhere else, instead of the predictor.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value;
    logic              typed;
    logic [VAL_W-1:0]  first_value;
    logic              first_sat;
  } stim_row_t;

  // One product element as it should leave the block.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic             sat;
    logic             last;
  } product_word_t;

  // Directed part. Only element 0 of the operands is loaded before the typed rows,
  // so every other element of those products is zero.
  localparam int N_DIRECTED = 22;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Product straight after reset: both stores read as zero.
    '{KIND_COMPUTE,    4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    // Largest positive times largest positive clamps high.
    '{KIND_LOAD_LEFT,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD_RIGHT, 4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{KIND_COMPUTE,    4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
    // Most negative times largest positive clamps low.
    '{KIND_LOAD_LEFT,  4'd0,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{KIND_COMPUTE,    4'd0,  32'h0000_0000, 1'b1, 32'h8000_0000, 1'b1},
    // Most negative squared clamps high.
    '{KIND_LOAD_RIGHT, 4'd0,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{KIND_COMPUTE,    4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
    // One times one is one, no clamping.
    '{KIND_LOAD_LEFT,  4'd0,  32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD_RIGHT, 4'd0,  32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{KIND_COMPUTE,    4'd0,  32'h0000_0000, 1'b1, 32'h0001_0000, 1'b0},
    // Smallest negative step times one: the shift keeps it exact and negative.
    '{KIND_LOAD_LEFT,  4'd0,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{KIND_COMPUTE,    4'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // The unused code must leave both stores alone and produce nothing.
    '{KIND_UNUSED,     4'd15, 32'hDEAD_BEEF, 1'b0, 32'h0, 1'b0},
    '{KIND_COMPUTE,    4'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // Scattered loads, including the last index, checked by the predictor.
    '{KIND_LOAD_LEFT,  4'd15, 32'h0002_0000, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD_RIGHT, 4'd15, 32'hFFFF_0000, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD_LEFT,  4'd5,  32'h0000_8000, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD_RIGHT, 4'd6,  32'h0003_0000, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD_LEFT,  4'd3,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD_RIGHT, 4'd12, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{KIND_COMPUTE,    4'd0,  32'h0000_0000, 1'b0, 32'h0, 1'b0}
  };

  logic                clk;
  logic                rst           = 1'b1;
  logic                item_valid    = 1'b0;
  logic                item_stall;
  logic [KIND_W-1:0]   kind          = KIND_LOAD_LEFT;
  logic [IDX_W-1:0]    element_index = '0;
  logic [VAL_W-1:0]    element_value = '0;
  logic                result_valid;
  logic                result_stall  = 1'b0;
  logic [IDX_W-1:0]    out_index;
  logic [VAL_W-1:0]    out_value;
  logic                saturated;
  logic                last;

  // The bench's own copy of the operand stores, and the products still owed by the block.
  logic [VAL_W-1:0] left_store  [CELLS];
  logic [VAL_W-1:0] right_store [CELLS];
  product_word_t    pending_products [$];
  product_word_t    head_product;

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  stall_burst = 0;
  logic calm = 1'b0;

  matrix4x4_multiply dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kind          (kind),
    .element_index (element_index),
    .element_value (element_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_index     (out_index),
    .out_value     (out_value),
    .saturated     (saturated),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle counter and the overall watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Product element e of the bench's stores. The four exact products are summed in a
  // 66-bit accumulator so nothing is lost, then shifted arithmetically and clamped.
  task automatic predict_element(input int e, output logic [VAL_W-1:0] value,
                                 output logic sat);
    logic signed [65:0] acc;
    logic signed [65:0] lhs;
    logic signed [65:0] rhs;
    logic signed [49:0] shifted;
    int row;
    int col;
    row = e / N;
    col = e % N;
    acc = '0;
    for (int k = 0; k < N; k++) begin
      lhs = $signed({{34{left_store[row*N+k][31]}}, left_store[row*N+k]});
      rhs = $signed({{34{right_store[k*N+col][31]}}, right_store[k*N+col]});
      acc = acc + lhs * rhs;
    end
    shifted = 50'(acc >>> FRAC);
    if (shifted > SUM_MAX) begin
      value = 32'h7FFF_FFFF;
      sat   = 1'b1;
    end else if (shifted < SUM_MIN) begin
      value = 32'h8000_0000;
      sat   = 1'b1;
    end else begin
      value = shifted[31:0];
      sat   = 1'b0;
    end
  endtask

  // Applies an accepted word to the bench's stores, and for a product queues the
  // sixteen elements it owes. A 4-bit index can never fall outside the 4x4 store,
  // so the out-of-range load case cannot be reached in this build.
  task automatic accept_word(input stim_row_t w);
    product_word_t p;
    case (w.kind)
      KIND_LOAD_LEFT:  left_store[w.idx]  = w.value;
      KIND_LOAD_RIGHT: right_store[w.idx] = w.value;
      KIND_COMPUTE: begin
        for (int e = 0; e < CELLS; e++) begin
          p.idx  = IDX_W'(e);
          p.last = (e == CELLS - 1);
          predict_element(e, p.value, p.sat);
          if (w.typed) begin
            p.value = (e == 0) ? w.first_value : '0;
            p.sat   = (e == 0) ? w.first_sat : 1'b0;
          end
          pending_products.push_back(p);
        end
      end
      default: ;
    endcase
  endtask

  // Offers one word, at times after a random idle burst, and returns once the
  // block has taken it. Valid stays high afterwards so back-to-back words need no gap.
  task automatic send_word(input stim_row_t w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid    <= 1'b1;
    kind          <= w.kind;
    element_index <= w.idx;
    element_value <= w.value;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    accept_word(w);
  endtask

  // Holds the input side quiet until every owed product element has come out.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // Operand values: small ones keep sums in range, wide ones drive saturation.
  function automatic logic [VAL_W-1:0] rand_value(input logic wide);
    int pick;
    int mag;
    pick = $urandom_range(0, 9);
    if (wide) begin
      case (pick % 4)
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return VAL_W'($urandom);
        default: begin
          mag = $urandom_range(0, 33554431);
          return VAL_W'(mag - 16777216);
        end
      endcase
    end
    case (pick)
      0: return '0;
      1: return 32'h0001_0000;
      2: return 32'hFFFF_0000;
      default: begin
        mag = $urandom_range(0, 262143);
        return VAL_W'(mag - 131072);
      end
    endcase
  endfunction

  // Prefers an entry that holds a large value, so that small sets pull the stores
  // back toward the unsaturated range instead of clamping every element.
  function automatic logic [IDX_W-1:0] pick_index(input logic to_right);
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] i;
    logic signed [VAL_W-1:0] v;
    start = IDX_W'($urandom_range(0, CELLS - 1));
    for (int k = 0; k < CELLS; k++) begin
      i = start + IDX_W'(k);
      v = to_right ? right_store[i] : left_store[i];
      if (v > 32'sd1048576 || v < -32'sd1048576)
        return i;
    end
    return start;
  endfunction

  // Result side: random stall bursts, with regular quiet windows and none at the end.
  always @(posedge clk) begin
    if (rst || calm || (cycle_count % 1500) >= 1100) begin
      stall_burst = 0;
      result_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst = stall_burst - 1;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_burst = $urandom_range(1, 10) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Every word taken on the result side is held against the oldest owed element.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("unexpected result word, index %0d", out_index));
      end else begin
        head_product = pending_products.pop_front();
        if (out_index !== head_product.idx)
          report_mismatch($sformatf("out_index %0d, want %0d", out_index, head_product.idx));
        if (out_value !== head_product.value)
          report_mismatch($sformatf("element %0d out_value %h, want %h",
                                    head_product.idx, out_value, head_product.value));
        if (saturated !== head_product.sat)
          report_mismatch($sformatf("element %0d saturated %b, want %b",
                                    head_product.idx, saturated, head_product.sat));
        if (last !== head_product.last)
          report_mismatch($sformatf("element %0d last %b, want %b",
                                    head_product.idx, last, head_product.last));
      end
    end
  end

  initial begin
    stim_row_t w;
    int   words_sent;
    int   set_len;
    int   guard;
    logic wide_set;
    logic drained_once;

    for (int i = 0; i < CELLS; i++) begin
      left_store[i]  = '0;
      right_store[i] = '0;
    end
    words_sent   = 0;
    drained_once = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_word(DIRECTED[i]);

    // Let the directed products finish before the random part starts.
    wait_drained();

    // Random part: sets of loads followed by a product, with stray unused words
    // mixed in and now and then a set that runs on into the next without a product.
    while (words_sent < RANDOM_ITEMS) begin
      if (words_sent >= CALM_AFTER)
        calm = 1'b1;
      if (!drained_once && words_sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      wide_set = ($urandom_range(0, 3) == 0);
      set_len  = $urandom_range(1, 6);
      for (int j = 0; j < set_len; j++) begin
        if ($urandom_range(0, 15) == 0) begin
          w = '0;
          w.kind  = KIND_UNUSED;
          w.idx   = IDX_W'($urandom_range(0, CELLS - 1));
          w.value = VAL_W'($urandom);
          send_word(w);
        end
        w = '0;
        w.kind  = $urandom_range(0, 1) ? KIND_LOAD_RIGHT : KIND_LOAD_LEFT;
        w.idx   = (!wide_set && $urandom_range(0, 1) == 1)
                  ? pick_index(w.kind == KIND_LOAD_RIGHT)
                  : IDX_W'($urandom_range(0, CELLS - 1));
        w.value = rand_value(wide_set);
        send_word(w);
        words_sent++;
      end
      if ($urandom_range(0, 5) != 0) begin
        w = '0;
        w.kind  = KIND_COMPUTE;
        w.idx   = IDX_W'($urandom_range(0, CELLS - 1));
        w.value = VAL_W'($urandom);
        send_word(w);
        words_sent++;
      end
    end

    // Close with a product so the final stores are always read out.
    w = '0;
    w.kind = KIND_COMPUTE;
    send_word(w);
    item_valid <= 1'b0;

    guard = 0;
    while (pending_products.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_products.size() != 0)
      report_mismatch($sformatf("%0d product elements never arrived",
                                pending_products.size()));

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
